@@ hdl/ibsa_pkg.sv @@
`timescale 1ns / 1ps

package ibsa_pkg;

  // Fixed field widths of the result word and the configuration port.
  localparam int MEAN_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int LANES      = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] INIT_RESET  = COUNT_W'(100);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = CFG_IDX_W'(1);

  // Per-step commands from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lane_ctl_t;

  // Width of the signed difference between a scaled sample and a mean.
  function automatic int diff_width(input int sw, input int fb);
    return ((sw + fb > MEAN_W) ? sw + fb : MEAN_W) + 1;
  endfunction

endpackage

@@ hdl/ibsa_lane.sv @@
`timescale 1ns / 1ps

module ibsa_lane #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ibsa_pkg::lane_ctl_t                    ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  input  logic [ibsa_pkg::COUNT_W-1:0]           divisor,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean
);

  localparam int DW    = ibsa_pkg::diff_width(SAMPLE_WIDTH, FRAC_BITS);
  localparam int SUM_W = DW + 2;
  localparam int MW    = ibsa_pkg::MEAN_W;
  localparam int CW    = ibsa_pkg::COUNT_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-MW+1){1'b1}}, {(MW-1){1'b0}}};

  logic [DW-1:0]          mag;
  logic [CW-1:0]          rem;
  logic                   neg;

  logic signed [DW-1:0]   scaled;
  logic signed [DW-1:0]   mean_ext;
  logic signed [DW-1:0]   diff;
  logic [DW-1:0]          diff_mag;
  logic [CW:0]            trial;
  logic                   fits;
  logic [CW-1:0]          rem_next;
  logic signed [SUM_W-1:0] quo;
  logic signed [SUM_W-1:0] sum;
  logic signed [MW-1:0]   mean_next;

  // Difference between the scaled sample and the current mean.
  always_comb begin
    scaled   = $signed({{(DW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample}) <<< FRAC_BITS;
    mean_ext = $signed({{(DW-MW){mean[MW-1]}}, mean});
    diff     = scaled - mean_ext;
    diff_mag = diff[DW-1] ? DW'(-diff) : diff;
  end

  // One restoring division step: the quotient shifts into the dividend register.
  always_comb begin
    trial    = {rem, mag[DW-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
  end

  // Signed quotient added to the mean and clamped to the 32-bit range.
  always_comb begin
    quo = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = $signed({{(SUM_W-MW){mean[MW-1]}}, mean}) + quo;
    if (sum > SUM_MAX) begin
      mean_next = {1'b0, {(MW-1){1'b1}}};
    end else if (sum < SUM_MIN) begin
      mean_next = {1'b1, {(MW-1){1'b0}}};
    end else begin
      mean_next = sum[MW-1:0];
    end
  end

  // The mean is state and resets to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
    end else if (ctl.commit) begin
      mean <= mean_next;
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= diff_mag;
      neg <= diff[DW-1];
      rem <= '0;
    end else if (ctl.step) begin
      mag <= {mag[DW-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

@@ hdl/imu_static_bias_averager_top.sv @@
`timescale 1ns / 1ps

// Static bias averager for a six-axis IMU. Each accepted word (six signed samples and a
// group-end mark) yields one result word holding the six running means in Q16.16, the
// divisor for the next sample and the done flag. While enabled and not yet done, every
// axis updates mean += (sample - mean) / count in its own lane; the six lanes share one
// sequencer and each runs a restoring divider that retires one quotient bit per cycle.
// A processed word goes through the run, commit and finish states, with one step per
// quotient bit of DW = max(SAMPLE_WIDTH + FRAC_BITS, 32) + 1 in the run state; a word
// that is ignored (block disabled or initialization done) goes straight to finish. One
// word is worked on at a time; a finished result waits in the output register while the
// next word is accepted. Configuration must only be written while no word is in flight; the block does not check.

module imu_static_bias_averager_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         acc_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         acc_y,
  input  logic signed [SAMPLE_WIDTH-1:0]         acc_z,
  input  logic signed [SAMPLE_WIDTH-1:0]         gyr_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         gyr_y,
  input  logic signed [SAMPLE_WIDTH-1:0]         gyr_z,
  input  logic                                   group_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_acc_x,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_acc_y,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_acc_z,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_gyr_x,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_gyr_y,
  output logic signed [ibsa_pkg::MEAN_W-1:0]     mean_gyr_z,
  output logic [ibsa_pkg::COUNT_W-1:0]           sample_count,
  output logic                                   init_done,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ibsa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ibsa_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int DW     = ibsa_pkg::diff_width(SAMPLE_WIDTH, FRAC_BITS);
  localparam int STEP_W = $clog2(DW + 1);
  localparam int MW     = ibsa_pkg::MEAN_W;
  localparam int CW     = ibsa_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_COMMIT,
    S_FIN
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   steps;
  logic [CW-1:0]       count;
  logic                done_flag;
  logic                grp;
  logic                enable;
  logic [CW-1:0]       init_count;

  logic                accept;
  logic                process;
  logic                out_free;
  logic [CW-1:0]       count_next;
  ibsa_pkg::lane_ctl_t ctl;

  logic signed [SAMPLE_WIDTH-1:0] samples [ibsa_pkg::LANES];
  logic signed [MW-1:0]           means   [ibsa_pkg::LANES];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign process   = enable && !done_flag;
  assign out_free  = !out_valid || !out_stall;

  assign count_next = (count == ibsa_pkg::COUNT_MAX) ? count : count + CW'(1);

  // Lane commands follow the sequencer state.
  always_comb begin
    ctl.load   = accept && process;
    ctl.step   = (state == S_RUN);
    ctl.commit = (state == S_COMMIT);
  end

  assign samples[0] = acc_x;
  assign samples[1] = acc_y;
  assign samples[2] = acc_z;
  assign samples[3] = gyr_x;
  assign samples[4] = gyr_y;
  assign samples[5] = gyr_z;

  // One averaging lane per axis.
  for (genvar i = 0; i < ibsa_pkg::LANES; i++) begin : g_lane
    ibsa_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (samples[i]),
      .divisor(count),
      .mean   (means[i])
    );
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      init_count <= ibsa_pkg::INIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ibsa_pkg::REG_ENABLE:     enable     <= cfg_data[0];
        ibsa_pkg::REG_INIT_COUNT: init_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, count and done state, and the merged output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      steps     <= '0;
      count     <= ibsa_pkg::COUNT_RESET;
      done_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The finish state reloads the result register itself when it is free.
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            grp   <= group_end;
            steps <= STEP_W'(DW);
            state <= process ? S_RUN : S_FIN;
          end
        end
        S_RUN: begin
          steps <= steps - STEP_W'(1);
          if (steps == STEP_W'(1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          count <= count_next;
          if (grp && (count_next > init_count)) begin
            done_flag <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            mean_acc_x   <= means[0];
            mean_acc_y   <= means[1];
            mean_acc_z   <= means[2];
            mean_gyr_x   <= means[3];
            mean_gyr_y   <= means[4];
            mean_gyr_z   <= means[5];
            sample_count <= count;
            init_done    <= done_flag;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/ibsa_checker.sv @@
`timescale 1ns / 1ps

module ibsa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ibsa_pkg::MEAN_W-1:0]        mean_acc_x,
  input logic [ibsa_pkg::COUNT_W-1:0]       sample_count,
  input logic                               init_done
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_acc_x) && $stable(sample_count))
    else $error("stalled result word changed");

  // One word at a time: after acceptance the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in flight");

  // The divisor never reads zero and never decreases.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count != '0)
    else $error("sample count is zero");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> sample_count >= $past(sample_count))
    else $error("sample count decreased");

  // Once initialization is done it stays done.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && init_done |=> init_done)
    else $error("init_done cleared");

endmodule

bind imu_static_bias_averager_top ibsa_checker u_ibsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .mean_acc_x  (mean_acc_x),
  .sample_count(sample_count),
  .init_done   (init_done)
);

@@ tb/imu_bias_mean_checker.sv @@
`timescale 1ns / 1ps

module imu_bias_mean_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      acc_x,
  input  logic signed [SAMPLE_WIDTH-1:0]      acc_y,
  input  logic signed [SAMPLE_WIDTH-1:0]      acc_z,
  input  logic signed [SAMPLE_WIDTH-1:0]      gyr_x,
  input  logic signed [SAMPLE_WIDTH-1:0]      gyr_y,
  input  logic signed [SAMPLE_WIDTH-1:0]      gyr_z,
  input  logic                                group_end,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_acc_x,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_acc_y,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_acc_z,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_gyr_x,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_gyr_y,
  input  logic signed [ibsa_pkg::MEAN_W-1:0]  mean_gyr_z,
  input  logic [ibsa_pkg::COUNT_W-1:0]        sample_count,
  input  logic                                init_done,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ibsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ibsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  faults,
  output int                                  words_pending
);

  import ibsa_pkg::*;

  typedef struct packed {
    logic signed [MEAN_W-1:0] acc_x;
    logic signed [MEAN_W-1:0] acc_y;
    logic signed [MEAN_W-1:0] acc_z;
    logic signed [MEAN_W-1:0] gyr_x;
    logic signed [MEAN_W-1:0] gyr_y;
    logic signed [MEAN_W-1:0] gyr_z;
    logic [COUNT_W-1:0]       count;
    logic                     done;
  } bias_report_t;

  localparam longint MEAN_HI = (longint'(1) <<< (MEAN_W - 1)) - 1;
  localparam longint MEAN_LO = -(longint'(1) <<< (MEAN_W - 1));

  // Predicted state of the averager and its registers.
  logic signed [MEAN_W-1:0] axis_mean [LANES];
  logic [COUNT_W-1:0]       divisor;
  logic                     calibrated;
  logic                     enable_reg;
  logic [COUNT_W-1:0]       threshold_reg;

  bias_report_t expected_reports [$];
  int           fault_total;

  initial begin
    faults        = 0;
    words_pending = 0;
  end

  // One incremental mean step in Q format: the quotient truncates toward zero and
  // the new mean saturates to the signed mean width.
  function automatic logic signed [MEAN_W-1:0] next_mean(
    input logic signed [MEAN_W-1:0]       mean,
    input logic signed [SAMPLE_WIDTH-1:0] sample,
    input logic [COUNT_W-1:0]             n
  );
    longint scaled;
    longint quot;
    longint sum;
    scaled = longint'(sample) * (longint'(1) <<< FRAC_BITS);
    quot   = (scaled - longint'(mean)) / ((n == '0) ? longint'(1) : longint'(n));
    sum    = longint'(mean) + quot;
    if (sum > MEAN_HI) sum = MEAN_HI;
    if (sum < MEAN_LO) sum = MEAN_LO;
    return sum[MEAN_W-1:0];
  endfunction

  function automatic bias_report_t current_report();
    bias_report_t r;
    r.acc_x = axis_mean[0];
    r.acc_y = axis_mean[1];
    r.acc_z = axis_mean[2];
    r.gyr_x = axis_mean[3];
    r.gyr_y = axis_mean[4];
    r.gyr_z = axis_mean[5];
    r.count = divisor;
    r.done  = calibrated;
    return r;
  endfunction

  // Watch all three channels, predict each accepted word and check each result word.
  always @(posedge clk) begin : watch
    logic signed [SAMPLE_WIDTH-1:0] sample [LANES];
    bias_report_t got;
    bias_report_t want;
    if (rst) begin
      for (int i = 0; i < LANES; i++) axis_mean[i] = '0;
      divisor       = COUNT_RESET;
      calibrated    = 1'b0;
      enable_reg    = 1'b1;
      threshold_reg = INIT_RESET;
      expected_reports.delete();
      fault_total   = 0;
      faults        <= 0;
      words_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENABLE) enable_reg = cfg_data[0];
        else if (cfg_index == REG_INIT_COUNT) threshold_reg = cfg_data[COUNT_W-1:0];
      end

      // A disabled block or a finished calibration leaves the state untouched.
      if (in_valid && !in_stall) begin
        sample[0] = acc_x;
        sample[1] = acc_y;
        sample[2] = acc_z;
        sample[3] = gyr_x;
        sample[4] = gyr_y;
        sample[5] = gyr_z;
        if (enable_reg && !calibrated) begin
          for (int i = 0; i < LANES; i++) axis_mean[i] = next_mean(axis_mean[i], sample[i], divisor);
          if (divisor != COUNT_MAX) divisor = divisor + 1'b1;
          if (group_end && divisor > threshold_reg) calibrated = 1'b1;
        end
        expected_reports.push_back(current_report());
      end

      if (out_valid && !out_stall) begin
        got.acc_x = mean_acc_x;
        got.acc_y = mean_acc_y;
        got.acc_z = mean_acc_z;
        got.gyr_x = mean_gyr_x;
        got.gyr_y = mean_gyr_y;
        got.gyr_z = mean_gyr_z;
        got.count = sample_count;
        got.done  = init_done;
        if (expected_reports.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("%0t: result word with nothing expected: count %0d done %0b",
                     $realtime, got.count, got.done);
        end else begin
          want = expected_reports.pop_front();
          if (got.acc_x !== want.acc_x || got.acc_y !== want.acc_y ||
              got.acc_z !== want.acc_z || got.gyr_x !== want.gyr_x ||
              got.gyr_y !== want.gyr_y || got.gyr_z !== want.gyr_z ||
              got.count !== want.count || got.done !== want.done) begin
            fault_total++;
            if (fault_total <= 10) begin
              $display("%0t: mismatch, expected acc %0d %0d %0d gyr %0d %0d %0d count %0d done %0b",
                       $realtime, want.acc_x, want.acc_y, want.acc_z,
                       want.gyr_x, want.gyr_y, want.gyr_z, want.count, want.done);
              $display("%0t:           actual acc %0d %0d %0d gyr %0d %0d %0d count %0d done %0b",
                       $realtime, got.acc_x, got.acc_y, got.acc_z,
                       got.gyr_x, got.gyr_y, got.gyr_z, got.count, got.done);
            end
          end
        end
      end

      faults        <= fault_total;
      words_pending <= expected_reports.size();
    end
  end

endmodule

@@ tb/tb_imu_static_bias_averager_top.sv @@
`timescale 1ns / 1ps

module tb_imu_static_bias_averager_top;

  import ibsa_pkg::*;

  localparam int SW           = 16;
  localparam int FB           = 16;
  localparam int DRAIN_CYCLES = 48;
  localparam int SAMPLE_MAX   = (1 << (SW - 1)) - 1;
  localparam int SAMPLE_MIN   = -(1 << (SW - 1));
  localparam logic [COUNT_W-1:0] INIT_MAX = COUNT_MAX - 1'b1;

  typedef struct packed {
    logic signed [SW-1:0] acc_x;
    logic signed [SW-1:0] acc_y;
    logic signed [SW-1:0] acc_z;
    logic signed [SW-1:0] gyr_x;
    logic signed [SW-1:0] gyr_y;
    logic signed [SW-1:0] gyr_z;
    logic                 group_end;
  } imu_sample_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [SW-1:0]         acc_x     = '0;
  logic signed [SW-1:0]         acc_y     = '0;
  logic signed [SW-1:0]         acc_z     = '0;
  logic signed [SW-1:0]         gyr_x     = '0;
  logic signed [SW-1:0]         gyr_y     = '0;
  logic signed [SW-1:0]         gyr_z     = '0;
  logic                         group_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [MEAN_W-1:0]     mean_acc_x;
  logic signed [MEAN_W-1:0]     mean_acc_y;
  logic signed [MEAN_W-1:0]     mean_acc_z;
  logic signed [MEAN_W-1:0]     mean_gyr_x;
  logic signed [MEAN_W-1:0]     mean_gyr_y;
  logic signed [MEAN_W-1:0]     mean_gyr_z;
  logic [COUNT_W-1:0]           sample_count;
  logic                         init_done;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;

  int   faults;
  int   words_pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off      = 1'b0;
  logic enabled       = 1'b1;
  int   processed     = 0;
  int   axis_center [LANES];

  always #5 clk = ~clk;

  imu_static_bias_averager_top #(
    .SAMPLE_WIDTH(SW),
    .FRAC_BITS   (FB)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .gyr_x(gyr_x), .gyr_y(gyr_y), .gyr_z(gyr_z),
    .group_end(group_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .mean_acc_x(mean_acc_x), .mean_acc_y(mean_acc_y), .mean_acc_z(mean_acc_z),
    .mean_gyr_x(mean_gyr_x), .mean_gyr_y(mean_gyr_y), .mean_gyr_z(mean_gyr_z),
    .sample_count(sample_count), .init_done(init_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  imu_bias_mean_checker #(
    .SAMPLE_WIDTH(SW),
    .FRAC_BITS   (FB)
  ) mean_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .gyr_x(gyr_x), .gyr_y(gyr_y), .gyr_z(gyr_z),
    .group_end(group_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .mean_acc_x(mean_acc_x), .mean_acc_y(mean_acc_y), .mean_acc_z(mean_acc_z),
    .mean_gyr_x(mean_gyr_x), .mean_gyr_y(mean_gyr_y), .mean_gyr_z(mean_gyr_z),
    .sample_count(sample_count), .init_done(init_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .faults(faults), .words_pending(words_pending)
  );

  // Result side: random stall, or a solid hold-off while the pressure window is open.
  always @(posedge clk) begin
    out_stall <= hold_off || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  // Keeps the result side stalled for the length given by its argument so the block backs up.
  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  function automatic imu_sample_t make_word(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz,
                                            input logic ge);
    imu_sample_t s;
    s.acc_x     = SW'(ax);
    s.acc_y     = SW'(ay);
    s.acc_z     = SW'(az);
    s.gyr_x     = SW'(gx);
    s.gyr_y     = SW'(gy);
    s.gyr_z     = SW'(gz);
    s.group_end = ge;
    return s;
  endfunction

  // Mostly a noisy reading around a fixed bias; otherwise full-range, extreme or tiny.
  function automatic int axis_value(input int center, input int mode);
    int v;
    case (mode)
      0:       v = center + int'($urandom_range(0, 400)) - 200;
      1:       v = int'($urandom_range(0, 2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
      2: begin
        case ($urandom_range(3))
          0:       v = SAMPLE_MAX;
          1:       v = SAMPLE_MIN;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 16)) - 8;
    endcase
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v;
  endfunction

  function automatic imu_sample_t random_word();
    int pick;
    int mode;
    pick = $urandom_range(99);
    mode = (pick < 55) ? 0 : (pick < 75) ? 1 : (pick < 85) ? 2 : 3;
    return make_word(axis_value(axis_center[0], mode), axis_value(axis_center[1], mode),
                     axis_value(axis_center[2], mode), axis_value(axis_center[3], mode),
                     axis_value(axis_center[4], mode), axis_value(axis_center[5], mode),
                     $urandom_range(99) < 12);
  endfunction

  task automatic pick_centers();
    for (int i = 0; i < LANES; i++)
      axis_center[i] = (i < 3) ? int'($urandom_range(0, 40000)) - 20000
                               : int'($urandom_range(0, 1200)) - 600;
  endtask

  // Offer one word, with an optional gap first, and hold it until it is taken.
  task automatic send_word(input imu_sample_t s);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    acc_x     <= s.acc_x;
    acc_y     <= s.acc_y;
    acc_z     <= s.acc_z;
    gyr_x     <= s.gyr_x;
    gyr_y     <= s.gyr_y;
    gyr_z     <= s.gyr_z;
    group_end <= s.group_end;
    do @(posedge clk); while (in_stall);
    if (enabled) processed++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word(random_word());
  endtask

  // Stop offering and wait until every predicted result word has come out.
  task automatic wait_for_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Only bit 0 matters; the upper data bits carry noise.
  task automatic set_enable(input logic en);
    logic [CFG_DATA_W-1:0] data;
    data    = CFG_DATA_W'($urandom);
    data[0] = en;
    write_reg(REG_ENABLE, data);
    enabled = en;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // First word after reset divides by one, so the means take the samples as they are.
    send_word(make_word(SAMPLE_MAX, SAMPLE_MIN, 0, -1, 1, SAMPLE_MIN, 1'b1));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MAX, -1, 0, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    send_word(make_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                        SAMPLE_MAX, 1'b1));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                        SAMPLE_MIN, 1'b0));
    send_word(make_word(0, 0, 0, 0, 0, 0, 1'b1));
    send_word(make_word(-1, -1, -1, -1, -1, -1, 1'b0));
    send_word(make_word(1, -1, 2, -2, SAMPLE_MAX, SAMPLE_MIN, 1'b1));

    // Disabled: samples and group ends are ignored, even at the lowest threshold.
    wait_for_idle();
    set_enable(1'b0);
    write_reg(REG_INIT_COUNT, CFG_DATA_W'(1));
    send_word(make_word(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                        SAMPLE_MAX, 1'b1));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                        SAMPLE_MIN, 1'b1));
    pick_centers();
    send_word(random_word());
    send_word(make_word(5, -5, 7, -7, 9, -9, 1'b1));

    // A write to an index with no register behind it changes nothing.
    wait_for_idle();
    write_reg(CFG_IDX_W'($urandom_range(REG_INIT_COUNT + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    set_enable(1'b1);
    write_reg(REG_INIT_COUNT, INIT_MAX);

    // Group ends below the threshold keep the averaging going.
    send_word(make_word(SAMPLE_MAX, 0, SAMPLE_MIN, 0, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    send_word(make_word(100, -100, 16384, -16384, 3, -3, 1'b0));
    send_word(make_word(SAMPLE_MIN, SAMPLE_MAX, 0, -1, -1, 0, 1'b1));
    send_word(make_word(-200, 200, 8000, -30, 30, 0, 1'b0));
    send_word(make_word(1, 1, 1, 1, 1, 1, 1'b1));
    send_word(make_word(-2, -2, -2, -2, -2, -2, 1'b0));

    // Sender idles lightly, receiver heavily.
    wait_for_idle();
    pick_centers();
    send_idle_pct = 15;
    recv_idle_pct = 72;
    send_random(650);

    // The other way round, with a disabled stretch in the middle.
    wait_for_idle();
    write_reg(REG_INIT_COUNT, CFG_DATA_W'($urandom_range(4000, INIT_MAX - 1)));
    pick_centers();
    send_idle_pct = 72;
    recv_idle_pct = 15;
    send_random(320);
    wait_for_idle();
    set_enable(1'b0);
    send_random(50);
    wait_for_idle();
    set_enable(1'b1);
    send_random(330);

    // No idling; partway through the result side holds off so the block backs up.
    wait_for_idle();
    write_reg(REG_INIT_COUNT, INIT_MAX);
    pick_centers();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(250);
    fork
      hold_receiver(300);
    join_none
    send_random(350);

    // Threshold three above the current count: a group end at equality does not
    // finish, the next one does, and everything after that is held.
    wait_for_idle();
    write_reg(REG_INIT_COUNT, CFG_DATA_W'(processed + 1 + 3));
    repeat (6) begin
      send_word(make_word(axis_value(axis_center[0], 0), axis_value(axis_center[1], 0),
                          axis_value(axis_center[2], 0), axis_value(axis_center[3], 0),
                          axis_value(axis_center[4], 0), axis_value(axis_center[5], 0),
                          1'b1));
    end
    send_random(20);

    wait_for_idle();
    if (faults == 0 && words_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ imu_static_bias_averager_top.f @@
hdl/ibsa_pkg.sv
hdl/ibsa_lane.sv
hdl/imu_static_bias_averager_top.sv
hdl/ibsa_checker.sv
tb/imu_bias_mean_checker.sv
tb/tb_imu_static_bias_averager_top.sv
